>>> rtl/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int SIZE_BITS   = 13;
  localparam int BYTE_BITS   = 8;
  localparam int BTN_BITS    = 3;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam int RESET_X     = 160;
  localparam int RESET_Y     = 100;
  localparam int RESET_WIDTH = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [ADDR_BITS-1:0] {
    ADDR_SCREEN_WIDTH   = 4'h0,
    ADDR_SCREEN_HEIGHT  = 4'h4,
    ADDR_DISPLAY_ENABLE = 4'h8
  } reg_addr_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  typedef struct packed {
    logic                 aux_ready;
    logic [BYTE_BITS-1:0] data_byte;
  } mouse_word_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] screen_width;
    logic [SIZE_BITS-1:0] screen_height;
    logic                 display_enable;
  } cfg_t;

endpackage

>>> rtl/mouse_packet_cursor_tracker.sv
// Top level: configuration registers, input stage and tracking core.
// Each input word gives exactly one result word, the cursor position and
// buttons after that byte. One word per clock sustained while out_stall is
// low; a word passes the input register, then the single-pass update into
// the result register. Bytes with aux_ready low change nothing. Registers:
// screen width 0x0, height 0x4, display enable 0x8; write them only while
// idle. Applied packets clamp coordinates to min(size-1, 2**COORD_BITS-1).
module mouse_packet_cursor_tracker
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_aux_ready,
  input  logic [BYTE_BITS-1:0]  in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_cursor_x,
  output logic [COORD_BITS-1:0] out_cursor_y,
  output logic [BTN_BITS-1:0]   out_button_bits,
  output logic                  out_packet_complete,
  output logic                  out_position_updated
);

  cfg_t        cfg_r;
  logic        wr_en;
  logic        word_vld, word_take;
  mouse_word_t word;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width   <= SIZE_BITS'(RESET_WIDTH);
      cfg_r.screen_height  <= SIZE_BITS'(RESET_HEIGHT);
      cfg_r.display_enable <= 1'b0;
    end else if (wr_en) begin
      if (paddr == ADDR_SCREEN_WIDTH) begin
        cfg_r.screen_width <= pwdata[SIZE_BITS-1:0];
      end
      if (paddr == ADDR_SCREEN_HEIGHT) begin
        cfg_r.screen_height <= pwdata[SIZE_BITS-1:0];
      end
      if (paddr == ADDR_DISPLAY_ENABLE) begin
        cfg_r.display_enable <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SCREEN_WIDTH) begin
      prdata = DATA_BITS'(cfg_r.screen_width);
    end else if (paddr == ADDR_SCREEN_HEIGHT) begin
      prdata = DATA_BITS'(cfg_r.screen_height);
    end else if (paddr == ADDR_DISPLAY_ENABLE) begin
      prdata = DATA_BITS'(cfg_r.display_enable);
    end
  end

  mpct_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_aux_ready (in_aux_ready),
    .in_data_byte (in_data_byte),
    .word_vld     (word_vld),
    .word         (word),
    .word_take    (word_take)
  );

  mpct_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .word_vld             (word_vld),
    .word                 (word),
    .word_take            (word_take),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cursor_x         (out_cursor_x),
    .out_cursor_y         (out_cursor_y),
    .out_button_bits      (out_button_bits),
    .out_packet_complete  (out_packet_complete),
    .out_position_updated (out_position_updated)
  );

endmodule

>>> rtl/mpct_in_stage.sv
// Input register stage: holds one accepted word until the core takes it.
module mpct_in_stage
  import mpct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_aux_ready,
  input  logic [BYTE_BITS-1:0] in_data_byte,
  output logic                 word_vld,
  output mouse_word_t          word,
  input  logic                 word_take
);

  logic        vld_r, vld_nxt;
  mouse_word_t word_r;
  logic        accept;

  assign in_stall = vld_r & ~word_take;
  assign accept   = in_valid & ~in_stall;
  assign word_vld = vld_r;
  assign word     = word_r;

  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (word_take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r.aux_ready <= in_aux_ready;
      word_r.data_byte <= in_data_byte;
    end
  end

endmodule

>>> rtl/mpct_core.sv
// Packet assembly, cursor accumulate-and-clamp and the result register.
module mpct_core
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  word_vld,
  input  mouse_word_t           word,
  output logic                  word_take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_cursor_x,
  output logic [COORD_BITS-1:0] out_cursor_y,
  output logic [BTN_BITS-1:0]   out_button_bits,
  output logic                  out_packet_complete,
  output logic                  out_position_updated
);

  localparam int LB = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int CW = LB + 2;
  localparam logic [CW-1:0] COORD_MAX = CW'((1 << COORD_BITS) - 1);

  phase_t                phase_r, phase_nxt;
  logic [BYTE_BITS-1:0]  first_r, first_nxt;
  logic [BYTE_BITS-1:0]  second_r, second_nxt;
  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [BTN_BITS-1:0]   btn_r, btn_nxt;
  logic                  complete, updated;
  logic                  out_valid_r;
  logic [CW-1:0]         lim_x, lim_y, raw_x, raw_y, sum_x, sum_y;

  assign word_take = word_vld & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    raw_x = (cfg.screen_width == '0) ? '0 : CW'(cfg.screen_width) - CW'(1);
    raw_y = (cfg.screen_height == '0) ? '0 : CW'(cfg.screen_height) - CW'(1);
    lim_x = (raw_x > COORD_MAX) ? COORD_MAX : raw_x;
    lim_y = (raw_y > COORD_MAX) ? COORD_MAX : raw_y;
    sum_x = CW'(pos_x_r) + {{(CW-BYTE_BITS){second_r[BYTE_BITS-1]}}, second_r};
    sum_y = CW'(pos_y_r) - {{(CW-BYTE_BITS){word.data_byte[BYTE_BITS-1]}},
                            word.data_byte};
  end

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    btn_nxt    = btn_r;
    complete   = 1'b0;
    updated    = 1'b0;
    if (word.aux_ready) begin
      unique case (phase_r)
        PH_FIRST: begin
          first_nxt = word.data_byte;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          second_nxt = word.data_byte;
          phase_nxt  = PH_THIRD;
        end
        default: begin
          complete  = 1'b1;
          phase_nxt = PH_FIRST;
          if (cfg.display_enable) begin
            updated = 1'b1;
            btn_nxt = first_r[BTN_BITS-1:0];
            if (sum_x[CW-1]) begin
              pos_x_nxt = '0;
            end else if (sum_x > lim_x) begin
              pos_x_nxt = lim_x[COORD_BITS-1:0];
            end else begin
              pos_x_nxt = sum_x[COORD_BITS-1:0];
            end
            if (sum_y[CW-1]) begin
              pos_y_nxt = '0;
            end else if (sum_y > lim_y) begin
              pos_y_nxt = lim_y[COORD_BITS-1:0];
            end else begin
              pos_y_nxt = sum_y[COORD_BITS-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      first_r     <= '0;
      second_r    <= '0;
      pos_x_r     <= COORD_BITS'(RESET_X);
      pos_y_r     <= COORD_BITS'(RESET_Y);
      btn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (word_take) begin
        phase_r  <= phase_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        pos_x_r  <= pos_x_nxt;
        pos_y_r  <= pos_y_nxt;
        btn_r    <= btn_nxt;
      end
      out_valid_r <= word_take | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      out_cursor_x         <= pos_x_nxt;
      out_cursor_y         <= pos_y_nxt;
      out_button_bits      <= btn_nxt;
      out_packet_complete  <= complete;
      out_position_updated <= updated;
    end
  end

endmodule
